FILE: hw/rtl/ray_axis_rect_intersect_assert.svh
// Assertion macros for the ray against rectangle block.
// Used by modules that include this header; needs signals clk and arst_n in scope.
`ifndef RAY_AXIS_RECT_INTERSECT_ASSERT_SVH
`define RAY_AXIS_RECT_INTERSECT_ASSERT_SVH

// When the antecedent holds, the consequent must follow.
`define RAI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// The expression must never hold.
`define RAI_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

FILE: hw/rtl/rai_pkg.sv
// Shared types and constants of the ray against rectangle block.
// No dependencies.
`timescale 1ns / 1ps
package rai_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int UV_BITS = FRAC_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_MODE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_POS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_U_LO = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_U_HI = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_V_LO = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_V_HI = 3'd5;

	localparam logic [1:0] MODE_Z = 2'd0;
	localparam logic [1:0] MODE_X = 2'd1;
	localparam logic [1:0] MODE_Y = 2'd2;

	localparam logic [WORD_BITS-1:0] RESET_HI = WORD_BITS'(5 << FRAC_BITS);
	localparam logic [UV_BITS-1:0] UV_ONE = UV_BITS'(1 << FRAC_BITS);

	typedef struct packed {
		logic signed [WORD_BITS-1:0] origin_x;
		logic signed [WORD_BITS-1:0] origin_y;
		logic signed [WORD_BITS-1:0] origin_z;
		logic signed [WORD_BITS-1:0] dir_x;
		logic signed [WORD_BITS-1:0] dir_y;
		logic signed [WORD_BITS-1:0] dir_z;
		logic signed [WORD_BITS-1:0] t_min;
		logic signed [WORD_BITS-1:0] t_max;
	} ray_t;

	typedef struct packed {
		logic is_hit;
		logic signed [WORD_BITS-1:0] t_hit;
		logic [UV_BITS-1:0] u_coord;
		logic [UV_BITS-1:0] v_coord;
	} result_t;

	// Data carried alongside the t division.
	typedef struct packed {
		logic neg;
		logic miss;
		logic signed [WORD_BITS-1:0] t_min;
		logic signed [WORD_BITS-1:0] t_max;
		logic signed [WORD_BITS-1:0] ou;
		logic signed [WORD_BITS-1:0] du;
		logic signed [WORD_BITS-1:0] ov;
		logic signed [WORD_BITS-1:0] dv;
	} t_side_t;

	// Data carried alongside the u normalization.
	typedef struct packed {
		logic miss;
		logic [WORD_BITS-1:0] t;
		logic zero_span;
	} uv_side_t;
endpackage

FILE: hw/rtl/rai_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; carries an opaque side vector alongside each item.
`timescale 1ns / 1ps
module rai_div #(
	parameter int NW = 49,
	parameter int DW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [NW-1:0] out_quo,
	output logic [SW-1:0] out_side
);
	logic          vld_s  [1:NW];
	logic [NW-1:0] num_s  [1:NW];
	logic [NW-1:0] quo_s  [1:NW];
	logic [DW-1:0] rem_s  [1:NW];
	logic [DW-1:0] den_s  [1:NW];
	logic [SW-1:0] side_s [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          vld_i;
		logic [NW-1:0] num_i;
		logic [NW-1:0] quo_i;
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [SW-1:0] side_i;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		// The first stage takes the item straight from the ports.
		if (k == 0) begin : g_head
			assign vld_i = in_vld;
			assign num_i = in_num;
			assign quo_i = '0;
			assign rem_i = '0;
			assign den_i = in_den;
			assign side_i = in_side;
		end else begin : g_body
			assign vld_i = vld_s[k];
			assign num_i = num_s[k];
			assign quo_i = quo_s[k];
			assign rem_i = rem_s[k];
			assign den_i = den_s[k];
			assign side_i = side_s[k];
		end

		always_comb begin
			trial = {rem_i, num_i[NW-1]};
			diff = trial - {1'b0, den_i};
			ge = (trial >= {1'b0, den_i});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1] <= {num_i[NW-2:0], 1'b0};
			quo_s[k+1] <= {quo_i[NW-2:0], ge};
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k+1] <= den_i;
			side_s[k+1] <= side_i;
		end
	end

	assign out_vld = vld_s[NW];
	assign out_quo = quo_s[NW];
	assign out_side = side_s[NW];
endmodule

FILE: hw/rtl/ray_axis_rect_intersect.sv
// Throughput: one item per cycle; busy is never raised and done pulses once per item.
// Cost is set by the three bit-per-stage dividers (t, then u and v side by side).
// Reset clears all valid bits and restores the register defaults (u_hi and v_hi 5.0).
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps
module ray_axis_rect_intersect (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rai_pkg::ray_t                      ray,
	output logic                               done,
	output rai_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rai_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rai_pkg::WORD_BITS-1:0]      cfg_data
);
	import rai_pkg::*;
	`include "ray_axis_rect_intersect_assert.svh"

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	// Numerator widths of both dividers: a (W+1)-bit value shifted up by F.
	localparam int NW1 = W + 1 + F;
	localparam int NW2 = W + 1 + F;
	// Width that holds origin plus the scaled product exactly.
	localparam int CW = 2 * W - F + 1;
	localparam int LAT_CYC = NW1 + NW2 + 6;

	// The pipeline never stalls, so a new item is taken every cycle and the
	// configuration port is always ready.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	logic [1:0]          plane_mode_q;
	logic signed [W-1:0] plane_pos_q;
	logic signed [W-1:0] u_lo_q;
	logic signed [W-1:0] u_hi_q;
	logic signed [W-1:0] v_lo_q;
	logic signed [W-1:0] v_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_mode_q <= MODE_Z;
			plane_pos_q <= '0;
			u_lo_q <= '0;
			u_hi_q <= RESET_HI;
			v_lo_q <= '0;
			v_hi_q <= RESET_HI;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PLANE_MODE: plane_mode_q <= cfg_data[1:0];
				REG_PLANE_POS:  plane_pos_q <= cfg_data;
				REG_U_LO:       u_lo_q <= cfg_data;
				REG_U_HI:       u_hi_q <= cfg_data;
				REG_V_LO:       v_lo_q <= cfg_data;
				REG_V_HI:       v_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1: pick the normal axis and the two in-plane axes, form the
	// numerator plane_pos - origin_n and split both operands into sign and
	// magnitude, since the divider works on unsigned values and the quotient
	// truncates toward zero.
	logic signed [W-1:0] on, dn;
	logic signed [W:0]   num;
	logic [W:0]          num_mag;
	logic [W-1:0]        den_mag;
	t_side_t             side_in;

	always_comb begin
		on = ray.origin_z;
		dn = ray.dir_z;
		side_in.ou = ray.origin_x;
		side_in.du = ray.dir_x;
		side_in.ov = ray.origin_y;
		side_in.dv = ray.dir_y;
		side_in.miss = 1'b0;
		case (plane_mode_q)
			MODE_Z: begin
			end
			MODE_X: begin
				on = ray.origin_x;
				dn = ray.dir_x;
				side_in.ou = ray.origin_z;
				side_in.du = ray.dir_z;
			end
			MODE_Y: begin
				on = ray.origin_y;
				dn = ray.dir_y;
				side_in.ou = ray.origin_z;
				side_in.du = ray.dir_z;
				side_in.ov = ray.origin_x;
				side_in.dv = ray.dir_x;
			end
			default: side_in.miss = 1'b1;
		endcase
		num = {plane_pos_q[W-1], plane_pos_q} - {on[W-1], on};
		num_mag = num[W] ? (W+1)'(-num) : num;
		den_mag = dn[W-1] ? W'(-dn) : dn;
		side_in.neg = num[W] ^ dn[W-1];
		if (dn == '0) begin
			side_in.miss = 1'b1;
		end
		side_in.t_min = ray.t_min;
		side_in.t_max = ray.t_max;
	end

	logic            v_s1;
	logic [NW1-1:0]  num_s1;
	logic [W-1:0]    den_s1;
	t_side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= {num_mag, {F{1'b0}}};
		den_s1 <= den_mag;
		side_s1 <= side_in;
	end

	// t division, one quotient bit per stage.
	logic           tdiv_vld;
	logic [NW1-1:0] tdiv_quo;
	t_side_t        tdiv_side;

	rai_div #(
		.NW(NW1),
		.DW(W),
		.SW($bits(t_side_t))
	) u_tdiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(v_s1),
		.in_num(num_s1),
		.in_den(den_s1),
		.in_side(side_s1),
		.out_vld(tdiv_vld),
		.out_quo(tdiv_quo),
		.out_side(tdiv_side)
	);

	// Stage 2: restore the sign, reject a quotient outside the signed word
	// and a t outside the ray's window.
	logic                t_ovf;
	logic signed [W-1:0] t_val;
	logic                t_out;

	always_comb begin
		t_ovf = (tdiv_quo[NW1-1:W-1] != '0);
		if (tdiv_side.neg && tdiv_quo == NW1'(1) << (W - 1)) begin
			t_ovf = 1'b0;
		end
		t_val = tdiv_side.neg ? W'(-tdiv_quo[W-1:0]) : tdiv_quo[W-1:0];
		t_out = (t_val < tdiv_side.t_min) || (t_val > tdiv_side.t_max);
	end

	logic                v_s2, miss_s2;
	logic signed [W-1:0] t_s2, ou_s2, du_s2, ov_s2, dv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= tdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		miss_s2 <= tdiv_side.miss || t_ovf || t_out;
		t_s2 <= t_val;
		ou_s2 <= tdiv_side.ou;
		du_s2 <= tdiv_side.du;
		ov_s2 <= tdiv_side.ov;
		dv_s2 <= tdiv_side.dv;
	end

	// Stage 3: t times each in-plane direction.
	logic                  v_s3, miss_s3;
	logic signed [W-1:0]   t_s3, ou_s3, ov_s3;
	logic signed [2*W-1:0] pu_s3, pv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		miss_s3 <= miss_s2;
		t_s3 <= t_s2;
		ou_s3 <= ou_s2;
		ov_s3 <= ov_s2;
		pu_s3 <= t_s2 * du_s2;
		pv_s3 <= t_s2 * dv_s2;
	end

	// Stage 4: coordinate = origin + floor(product / 2^F), kept at full width
	// so that the bound compares see the exact value.
	logic                 v_s4, miss_s4;
	logic signed [W-1:0]  t_s4;
	logic signed [CW-1:0] cu_s4, cv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		miss_s4 <= miss_s3;
		t_s4 <= t_s3;
		cu_s4 <= CW'(ou_s3) + CW'(pu_s3 >>> F);
		cv_s4 <= CW'(ov_s3) + CW'(pv_s3 >>> F);
	end

	// Stage 5: bound checks, then the offset and span for normalization.
	// Inside the bounds the offset never exceeds the span, so both fit W+1
	// unsigned bits.
	logic                 u_out, v_out;
	logic signed [CW-1:0] offu_full, offv_full;

	always_comb begin
		u_out = (cu_s4 < CW'(u_lo_q)) || (cu_s4 > CW'(u_hi_q));
		v_out = (cv_s4 < CW'(v_lo_q)) || (cv_s4 > CW'(v_hi_q));
		offu_full = cu_s4 - CW'(u_lo_q);
		offv_full = cv_s4 - CW'(v_lo_q);
	end

	logic         v_s5;
	uv_side_t     uside_s5;
	logic         zv_s5;
	logic [W:0]   offu_s5, offv_s5, spanu_s5, spanv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		uside_s5.miss <= miss_s4 || u_out || v_out;
		uside_s5.t <= t_s4;
		uside_s5.zero_span <= (u_hi_q == u_lo_q);
		zv_s5 <= (v_hi_q == v_lo_q);
		offu_s5 <= offu_full[W:0];
		offv_s5 <= offv_full[W:0];
		spanu_s5 <= {u_hi_q[W-1], u_hi_q} - {u_lo_q[W-1], u_lo_q};
		spanv_s5 <= {v_hi_q[W-1], v_hi_q} - {v_lo_q[W-1], v_lo_q};
	end

	// Normalization dividers for u and v run side by side with equal latency.
	logic           udiv_vld, vdiv_vld;
	logic [NW2-1:0] udiv_quo, vdiv_quo;
	uv_side_t       udiv_side;
	logic           vdiv_zero;

	rai_div #(
		.NW(NW2),
		.DW(W + 1),
		.SW($bits(uv_side_t))
	) u_udiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(v_s5),
		.in_num({offu_s5, {F{1'b0}}}),
		.in_den(spanu_s5),
		.in_side(uside_s5),
		.out_vld(udiv_vld),
		.out_quo(udiv_quo),
		.out_side(udiv_side)
	);

	rai_div #(
		.NW(NW2),
		.DW(W + 1),
		.SW(1)
	) u_vdiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(v_s5),
		.in_num({offv_s5, {F{1'b0}}}),
		.in_den(spanv_s5),
		.in_side(zv_s5),
		.out_vld(vdiv_vld),
		.out_quo(vdiv_quo),
		.out_side(vdiv_zero)
	);

	// Output register: a miss forces every field to zero, and a zero-width
	// bound gives a normalized value of zero.
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= udiv_vld && vdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.is_hit <= !udiv_side.miss;
		result_q.t_hit <= udiv_side.miss ? '0 : udiv_side.t;
		result_q.u_coord <= (udiv_side.miss || udiv_side.zero_span) ? '0 : udiv_quo[UV_BITS-1:0];
		result_q.v_coord <= (udiv_side.miss || vdiv_zero) ? '0 : vdiv_quo[UV_BITS-1:0];
	end

	assign done = done_q;
	assign result = result_q;

	`RAI_ASSERT_IMP(a_fixed_latency, start && !busy, ##LAT_CYC done, "item did not finish on time")
	`RAI_ASSERT_IMP(a_miss_zero, done && !result.is_hit, (result.t_hit == '0 && result.u_coord == '0 && result.v_coord == '0), "miss with nonzero fields")
	`RAI_ASSERT_NEVER(a_uv_range, done && result.is_hit && (result.u_coord > UV_ONE || result.v_coord > UV_ONE), "normalized coordinate above one")
endmodule

FILE: sim/ray_axis_rect_intersect_tb.sv
// Self-checking testbench of the ray against axis-aligned rectangle block.
// Depends on rai_pkg and ray_axis_rect_intersect from the RTL folder.
`timescale 1ns / 1ps
module ray_axis_rect_intersect_tb;
	import rai_pkg::*;

	localparam int LATENCY = 105;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint T_TOP = 64'sd2147483647;
	localparam longint T_BOTTOM = -64'sd2147483648;
	localparam int ONE = 1 << FRAC_BITS;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;
	localparam logic [1:0] MODE_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	ray_t ray;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [WORD_BITS-1:0] cfg_data;

	// Our own copy of the rectangle registers, updated on every accepted write.
	logic [1:0] rect_mode;
	logic signed [WORD_BITS-1:0] rect_pos;
	logic signed [WORD_BITS-1:0] rect_u_lo;
	logic signed [WORD_BITS-1:0] rect_u_hi;
	logic signed [WORD_BITS-1:0] rect_v_lo;
	logic signed [WORD_BITS-1:0] rect_v_hi;

	result_t pending_hits[$];
	result_t oldest;
	int errors = 0;
	int cycles = 0;

	ray_axis_rect_intersect u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.ray(ray),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a correct run ends far below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Maps a coordinate into [0, 1] of its bounds; a degenerate span gives zero.
	function automatic logic [UV_BITS-1:0] uv_scale(input longint c, input longint lo,
			input longint hi);
		longint q;
		if (hi <= lo)
			return '0;
		q = ((c - lo) <<< FRAC_BITS) / (hi - lo);
		return q[UV_BITS-1:0];
	endfunction

	// Expected result of one ray against the rectangle as currently configured.
	function automatic result_t rect_hit(input ray_t r);
		longint on, dn, ou, du, ov, dv, t, cu, cv;
		result_t res;
		res = '0;
		case (rect_mode)
			MODE_Z: begin
				on = r.origin_z; dn = r.dir_z; ou = r.origin_x; du = r.dir_x;
				ov = r.origin_y; dv = r.dir_y;
			end
			MODE_X: begin
				on = r.origin_x; dn = r.dir_x; ou = r.origin_z; du = r.dir_z;
				ov = r.origin_y; dv = r.dir_y;
			end
			MODE_Y: begin
				on = r.origin_y; dn = r.dir_y; ou = r.origin_z; du = r.dir_z;
				ov = r.origin_x; dv = r.dir_x;
			end
			default: return res;
		endcase
		if (dn == 0)
			return res;
		// Signed division truncates toward zero, as the hardware divider does.
		t = ((longint'(rect_pos) - on) <<< FRAC_BITS) / dn;
		if (t > T_TOP || t < T_BOTTOM)
			return res;
		if (t < longint'(r.t_min) || t > longint'(r.t_max))
			return res;
		// The arithmetic shift is the floor of the scaled product.
		cu = ou + ((t * du) >>> FRAC_BITS);
		cv = ov + ((t * dv) >>> FRAC_BITS);
		if (cu < longint'(rect_u_lo) || cu > longint'(rect_u_hi) ||
				cv < longint'(rect_v_lo) || cv > longint'(rect_v_hi))
			return res;
		res.is_hit = 1'b1;
		res.t_hit = t[WORD_BITS-1:0];
		res.u_coord = uv_scale(cu, rect_u_lo, rect_u_hi);
		res.v_coord = uv_scale(cv, rect_v_lo, rect_v_hi);
		return res;
	endfunction

	// Every done strobe retires the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				oldest = pending_hits.pop_front();
				if (result.is_hit !== oldest.is_hit) begin
					$error("is_hit expected %0d got %0d", oldest.is_hit, result.is_hit);
					errors++;
				end
				if (result.t_hit !== oldest.t_hit) begin
					$error("t_hit expected %0d got %0d", oldest.t_hit, result.t_hit);
					errors++;
				end
				if (result.u_coord !== oldest.u_coord) begin
					$error("u_coord expected %0d got %0d", oldest.u_coord, result.u_coord);
					errors++;
				end
				if (result.v_coord !== oldest.v_coord) begin
					$error("v_coord expected %0d got %0d", oldest.v_coord, result.v_coord);
					errors++;
				end
			end
		end
	end

	// Mostly back to back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one item; start stays high so the next call can follow without a bubble.
	task automatic send_ray(input ray_t r, input int gap);
		start <= 1'b1;
		ray <= r;
		do
			@(posedge clk);
		while (busy);
		pending_hits.push_back(rect_hit(r));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers start only when it is still high, so it is never driven twice in one step.
	task automatic stop_sending();
		if (start)
			start <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result has come and the pipeline is empty.
	task automatic drain();
		stop_sending();
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Valid drops to idle after each write, so back-to-back writes never drive valid twice.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WORD_BITS-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PLANE_MODE: rect_mode = d[1:0];
			REG_PLANE_POS: rect_pos = d;
			REG_U_LO: rect_u_lo = d;
			REG_U_HI: rect_u_hi = d;
			REG_V_LO: rect_v_lo = d;
			REG_V_HI: rect_v_hi = d;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rect(input logic [1:0] mode, input int pos, input int ulo, input int uhi,
			input int vlo, input int vhi);
		write_reg(REG_PLANE_MODE, WORD_BITS'(mode));
		write_reg(REG_PLANE_POS, pos);
		write_reg(REG_U_LO, ulo);
		write_reg(REG_U_HI, uhi);
		write_reg(REG_V_LO, vlo);
		write_reg(REG_V_HI, vhi);
	endtask

	function automatic ray_t make_ray(input int ox, input int oy, input int oz, input int dx,
			input int dy, input int dz, input int tmin, input int tmax);
		ray_t r;
		r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
		r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
		r.t_min = tmin; r.t_max = tmax;
		return r;
	endfunction

	function automatic int pick_signed(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// A ray aimed at a point near the rectangle so that many rays actually hit.
	function automatic ray_t aimed_ray();
		int t, dn, du, dv, pu, pv, on, ou, ov, tmin, tmax;
		longint ulo, uhi, vlo, vhi;
		ray_t r;
		ulo = rect_u_lo; uhi = rect_u_hi; vlo = rect_v_lo; vhi = rect_v_hi;
		t = $urandom_range(0, 6 * ONE);
		dn = pick_signed(2 * ONE);
		du = pick_signed(2 * ONE);
		dv = pick_signed(2 * ONE);
		pu = (uhi > ulo && uhi - ulo < 32'h7fff_0000) ?
			int'(ulo + $urandom_range(0, int'(uhi - ulo))) : int'(ulo) + pick_signed(2);
		pv = (vhi > vlo && vhi - vlo < 32'h7fff_0000) ?
			int'(vlo + $urandom_range(0, int'(vhi - vlo))) : int'(vlo) + pick_signed(2);
		on = rect_pos - int'((longint'(t) * dn) >>> FRAC_BITS);
		ou = pu - int'((longint'(t) * du) >>> FRAC_BITS);
		ov = pv - int'((longint'(t) * dv) >>> FRAC_BITS);
		tmin = ($urandom_range(0, 3) == 0) ? t - pick_signed(ONE) : -8 * ONE;
		tmax = ($urandom_range(0, 3) == 0) ? t + pick_signed(ONE) : 16 * ONE;
		case (rect_mode)
			MODE_X: r = make_ray(on, ov, ou, dn, dv, du, tmin, tmax);
			MODE_Y: r = make_ray(ov, on, ou, dv, dn, du, tmin, tmax);
			default: r = make_ray(ou, ov, on, du, dv, dn, tmin, tmax);
		endcase
		// Now and then dir_z or dir_x is zero, the normal one in the z and x modes.
		if ($urandom_range(0, 15) == 0)
			r.dir_z = '0;
		if ($urandom_range(0, 15) == 0)
			r.dir_x = '0;
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
		r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
		r.t_min = $urandom; r.t_max = $urandom;
		return r;
	endfunction

	// Extremes of the fields and each named corner, on the reset rectangle first.
	task automatic test_directed();
		// Straight down the z axis onto the rectangle interior.
		send_ray(make_ray(ONE, ONE, -2 * ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		// Corners of the inclusive bounds.
		send_ray(make_ray(5 * ONE, 5 * ONE, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		send_ray(make_ray(0, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 1);
		send_ray(make_ray(5 * ONE + 1, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		send_ray(make_ray(0, -1, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		// Window exactly on t, and t just outside on both sides.
		send_ray(make_ray(ONE, ONE, -2 * ONE, 0, 0, ONE, 2 * ONE, 2 * ONE), 0);
		send_ray(make_ray(ONE, ONE, -2 * ONE, 0, 0, ONE, 2 * ONE + 1, 4 * ONE), 2);
		send_ray(make_ray(ONE, ONE, -2 * ONE, 0, 0, ONE, 0, 2 * ONE - 1), 0);
		// Negative t from behind the origin, and a slanted ray.
		send_ray(make_ray(ONE, ONE, 2 * ONE, ONE / 2, 0, ONE, -8 * ONE, 8 * ONE), 0);
		send_ray(make_ray(0, 0, -3 * ONE, ONE, -ONE / 3, 3 * ONE, 0, 8 * ONE), 0);
		// Zero normal direction.
		send_ray(make_ray(ONE, ONE, -ONE, ONE, ONE, 0, -8 * ONE, 8 * ONE), 0);
		// Quotient far beyond the word: a distant origin with the smallest direction.
		send_ray(make_ray(0, 0, 32'sh8000_0000, 0, 0, 1, 32'sh8000_0000, 32'sh7fff_ffff), 3);
		send_ray(make_ray(0, 0, -ONE, 0, 0, -1, 32'sh8000_0000, 32'sh7fff_ffff), 0);
		// Largest, smallest and all-ones extremes of every field, then zero origins.
		send_ray(make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff), 0);
		send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0);
		send_ray(make_ray(-1, -1, -1, -1, -1, -1, 32'sh8000_0000, 32'sh7fff_ffff), 0);
		send_ray(make_ray(0, 0, 0, 0, 0, -1, 32'sh8000_0000, 32'sh7fff_ffff), 0);
		drain();

		// Each plane mode once, plus the unused mode that hits nothing.
		set_rect(MODE_X, ONE, -ONE, ONE, -ONE, ONE);
		send_ray(make_ray(-ONE, ONE / 2, ONE / 4, ONE, 0, 0, 0, 4 * ONE), 0);
		drain();
		set_rect(MODE_Y, -ONE, -ONE, ONE, -ONE, ONE);
		send_ray(make_ray(ONE / 4, ONE, ONE / 2, 0, -ONE, 0, 0, 4 * ONE), 0);
		drain();
		set_rect(MODE_NONE, 0, -ONE, ONE, -ONE, ONE);
		send_ray(make_ray(0, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		drain();

		// Empty bounds, then zero-width bounds that accept one coordinate.
		set_rect(MODE_Z, 0, ONE, -ONE, -ONE, ONE);
		send_ray(make_ray(0, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		drain();
		set_rect(MODE_Z, 0, ONE, ONE, 0, 0);
		send_ray(make_ray(ONE, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		send_ray(make_ray(ONE + 1, 0, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		drain();

		// Register indexes past the list must change nothing.
		set_rect(MODE_Z, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		write_reg(REG_SPARE_A, 32'hdead_beef);
		write_reg(REG_SPARE_B, 32'hffff_ffff);
		send_ray(make_ray(ONE, -ONE, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		send_ray(make_ray(32'sh7fff_ffff, 32'sh8000_0000, -ONE, 0, 0, ONE, 0, 4 * ONE), 0);
		drain();
	endtask

	// Random rectangles, the last one the widest, each followed by a run of mostly aimed rays.
	task automatic test_random(input int phases, input int per_phase);
		int lo, span, k;
		bit nogap;
		for (int p = 0; p < phases; p++) begin
			if (p == phases - 1) begin
				// Widest plane position and bounds.
				set_rect(MODE_Y, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
					32'sh8000_0000, 32'sh7fff_ffff);
			end else begin
				write_reg(REG_PLANE_MODE, ($urandom_range(0, 9) == 0) ? MODE_NONE :
					WORD_BITS'($urandom_range(0, 2)));
				write_reg(REG_PLANE_POS, ($urandom_range(0, 7) == 0) ? $urandom :
					pick_signed(4 * ONE));
				lo = pick_signed(8 * ONE);
				span = ($urandom_range(0, 9) == 0) ? pick_signed(ONE) :
					$urandom_range(ONE / 4, 10 * ONE);
				write_reg(REG_U_LO, lo);
				write_reg(REG_U_HI, lo + span);
				lo = pick_signed(8 * ONE);
				span = ($urandom_range(0, 9) == 0) ? pick_signed(ONE) :
					$urandom_range(ONE / 4, 10 * ONE);
				write_reg(REG_V_LO, lo);
				write_reg(REG_V_HI, lo + span);
			end
			for (int i = 0; i < per_phase; i++) begin
				// Stretches with no idling at all, every so often.
				if (i % 40 == 0)
					nogap = ($urandom_range(0, 2) == 0);
				k = $urandom_range(0, 9);
				send_ray((k < 7) ? aimed_ray() : noise_ray(), nogap ? 0 : pick_gap());
			end
			drain();
		end
	endtask

	// The sender holds off mid-stream until every expected result is back.
	task automatic test_pause_until_empty();
		set_rect(MODE_Z, 0, -4 * ONE, 4 * ONE, -4 * ONE, 4 * ONE);
		for (int i = 0; i < 30; i++)
			send_ray(aimed_ray(), 0);
		stop_sending();
		while (pending_hits.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 30; i++)
			send_ray(aimed_ray(), pick_gap());
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		ray <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		rect_mode = MODE_Z;
		rect_pos = '0;
		rect_u_lo = '0;
		rect_u_hi = RESET_HI;
		rect_v_lo = '0;
		rect_v_hi = RESET_HI;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause_until_empty();
		test_random(10, 115);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/rai_pkg.sv
hw/rtl/rai_div.sv
hw/rtl/ray_axis_rect_intersect.sv
sim/ray_axis_rect_intersect_tb.sv
